// File: rtl/spnbc_pkg.sv
package spnbc_pkg;

  localparam int unsigned ROUNDS = 3;
  localparam logic [7:0] HEADER_BYTES_RESET = 8'd20;
  localparam logic [7:0] POSITION_MAX = 8'hFF;

  typedef enum logic {
    CMD_ENCIPHER = 1'b0,
    CMD_DECIPHER = 1'b1
  } command_t;

  typedef struct packed {
    command_t   command;
    logic [7:0] data_byte;
    logic       last_of_packet;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       was_transformed;
    logic       out_last;
  } out_item_t;

  localparam logic [3:0] SBOX_FWD [16] = '{
    4'd1, 4'd3, 4'd5, 4'd7, 4'd9, 4'd11, 4'd13, 4'd15,
    4'd2, 4'd4, 4'd6, 4'd8, 4'd10, 4'd12, 4'd14, 4'd0
  };
  localparam logic [3:0] SBOX_INV [16] = '{
    4'd15, 4'd0, 4'd8, 4'd1, 4'd9, 4'd2, 4'd10, 4'd3,
    4'd11, 4'd4, 4'd12, 4'd5, 4'd13, 4'd6, 4'd14, 4'd7
  };

  // bit j of the input lands on bit PERM_x[j] of the output
  localparam logic [2:0] PERM_FWD [8] = '{
    3'd2, 3'd3, 3'd0, 3'd4, 3'd1, 3'd7, 3'd5, 3'd6
  };
  localparam logic [2:0] PERM_INV [8] = '{
    3'd2, 3'd4, 3'd0, 3'd1, 3'd3, 3'd6, 3'd7, 3'd5
  };

  localparam logic [7:0] ROUND_KEY [ROUNDS] = '{8'hEE, 8'h44, 8'h19};

  function automatic logic [7:0] subst_fwd(input logic [7:0] x);
    return {SBOX_FWD[x[7:4]], SBOX_FWD[x[3:0]]};
  endfunction

  function automatic logic [7:0] subst_inv(input logic [7:0] x);
    return {SBOX_INV[x[7:4]], SBOX_INV[x[3:0]]};
  endfunction

  function automatic logic [7:0] permute_fwd(input logic [7:0] x);
    logic [7:0] y;
    y = '0;
    for (int j = 0; j < 8; j++) begin
      y[PERM_FWD[j]] = x[j];
    end
    return y;
  endfunction

  function automatic logic [7:0] permute_inv(input logic [7:0] x);
    logic [7:0] y;
    y = '0;
    for (int j = 0; j < 8; j++) begin
      y[PERM_INV[j]] = x[j];
    end
    return y;
  endfunction

endpackage

// File: rtl/spnbc_round.sv
module spnbc_round (
  input  spnbc_pkg::command_t command,
  input  logic [7:0]          enc_key,
  input  logic [7:0]          dec_key,
  input  logic [7:0]          din,
  output logic [7:0]          dout
);

  logic [7:0] enc_out;
  logic [7:0] dec_out;

  assign enc_out = spnbc_pkg::permute_fwd(spnbc_pkg::subst_fwd(din)) ^ enc_key;
  assign dec_out = spnbc_pkg::subst_inv(spnbc_pkg::permute_inv(din ^ dec_key));

  always_comb begin
    case (command)
      spnbc_pkg::CMD_DECIPHER: dout = dec_out;
      default:                 dout = enc_out;
    endcase
  end

endmodule

// File: rtl/spnbc_cipher.sv
module spnbc_cipher (
  input  spnbc_pkg::command_t command,
  input  logic [7:0]          din,
  output logic [7:0]          dout
);

  logic [7:0] chain [spnbc_pkg::ROUNDS+1];

  assign chain[0] = din;

  // decipher walks the keys in reverse
  for (genvar r = 0; r < spnbc_pkg::ROUNDS; r++) begin : g_round
    spnbc_round u_round (
      .command (command),
      .enc_key (spnbc_pkg::ROUND_KEY[r]),
      .dec_key (spnbc_pkg::ROUND_KEY[spnbc_pkg::ROUNDS-1-r]),
      .din     (chain[r]),
      .dout    (chain[r+1])
    );
  end

  assign dout = chain[spnbc_pkg::ROUNDS];

endmodule

// File: rtl/spnbc_position.sv
module spnbc_position (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic [7:0] cfg_write_data,
  input  logic       advance,
  input  logic       last_of_packet,
  output logic       xform
);

  logic [7:0] header_bytes;
  logic [7:0] byte_position;
  logic [7:0] byte_position_next;

  assign xform = (byte_position >= header_bytes);

  always_comb begin
    byte_position_next = byte_position;
    if (advance) begin
      if (last_of_packet) begin
        byte_position_next = '0;
      end else if (byte_position != spnbc_pkg::POSITION_MAX) begin
        byte_position_next = byte_position + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes  <= spnbc_pkg::HEADER_BYTES_RESET;
      byte_position <= '0;
    end else begin
      byte_position <= byte_position_next;
      if (cfg_write_en) begin
        header_bytes <= cfg_write_data;
      end
    end
  end

endmodule

// File: rtl/spn_byte_cipher_packet_core.sv
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_ready   | in_data   (spnbc_pkg::in_item_t)
// out     | out | out_valid/out_ready | out_data  (spnbc_pkg::out_item_t)
// cfg     | in  | cfg_write_en        | cfg_write_data (header_bytes)
//
// One request per cycle sustained while out_ready holds; out_valid rises after
// accept, via input register and result register around the three cipher rounds.
// Position and header compare are resolved at acceptance.
// Synchronous active-high rst: pipeline empties, position 0, header_bytes 20.
// A stall at out back-pressures both stages; in_ready falls only when both are full.
module spn_byte_cipher_packet_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  spnbc_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output spnbc_pkg::out_item_t out_data,
  input  logic                 cfg_write_en,
  input  logic [7:0]           cfg_write_data
);

  logic                s1_valid;
  spnbc_pkg::in_item_t s1_item;
  logic                s1_xform;
  logic                s2_ready;
  logic                accept;
  logic                xform;
  logic [7:0]          cipher_byte;

  assign s2_ready = !out_valid || out_ready;
  assign in_ready = !s1_valid || s2_ready;
  assign accept   = in_valid && in_ready;

  spnbc_position u_position (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .advance        (accept),
    .last_of_packet (in_data.last_of_packet),
    .xform          (xform)
  );

  spnbc_cipher u_cipher (
    .command (s1_item.command),
    .din     (s1_item.data_byte),
    .dout    (cipher_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item  <= in_data;
      s1_xform <= xform;
    end
    if (s2_ready && s1_valid) begin
      out_data.out_byte        <= s1_xform ? cipher_byte : s1_item.data_byte;
      out_data.was_transformed <= s1_xform;
      out_data.out_last        <= s1_item.last_of_packet;
    end
  end

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_ready |=> s1_valid && $stable(s1_item) && $stable(s1_xform))
    else $error("input stage changed while stalled");

  a_s1_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_ready |=> out_valid && (out_data.out_last == $past(s1_item.last_of_packet)))
    else $error("request lost between stages");

  a_pass_through: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_ready && !s1_xform |=> out_data.out_byte == $past(s1_item.data_byte))
    else $error("header byte altered");

endmodule
